FILE: sv/slt_pkg.sv
`default_nettype none

package slt_pkg;

   localparam int TXN_W = 4;
   localparam int KEY_W = 48;

   typedef enum logic [1:0] {
      OP_LOCK_SHARED = 2'd0,
      OP_LOCK_EXCL   = 2'd1,
      OP_REL_SHARED  = 2'd2,
      OP_REL_ALL     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_CONFLICT = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_NONE     = 2'd3
   } status_type;

   typedef struct packed {
      op_type             operation;
      logic [TXN_W-1:0]   transaction;
      logic [KEY_W-1:0]   lock_key;
   } req_item_type;

   typedef struct packed {
      logic       granted;
      status_type status;
   } rsp_item_type;

   typedef struct packed {
      logic       granted;
      status_type status;
   } owner_result_type;

endpackage

`default_nettype wire

FILE: sv/slt_ram.sv
`default_nettype none

module slt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: sv/slt_owner_unit.sv
`default_nettype none

module slt_owner_unit #(
   parameter int TRANSACTIONS = 16
) (
   input  wire slt_pkg::op_type                 operation,
   input  wire logic [slt_pkg::TXN_W-1:0]       txn,
   input  wire logic [TRANSACTIONS-1:0]         txn_bit,
   input  wire logic [slt_pkg::TXN_W-1:0]       excl,
   input  wire logic [TRANSACTIONS-1:0]         shared,
   output slt_pkg::owner_result_type            result,
   output logic      [slt_pkg::TXN_W-1:0]       new_excl,
   output logic      [TRANSACTIONS-1:0]         new_shared
);

   logic excl_other;
   logic excl_mine;
   logic shared_mine;

   always_comb begin
      excl_other = (excl != '0) && (excl != txn);
      excl_mine  = (excl == txn);
      shared_mine = |(shared & txn_bit);
      new_excl   = excl;
      new_shared = shared;
      result.granted = 1'b0;
      result.status  = slt_pkg::STAT_NONE;
      unique case (operation)
         slt_pkg::OP_LOCK_SHARED: begin
            if (excl_other) begin
               result.status = slt_pkg::STAT_CONFLICT;
            end else begin
               new_shared     = shared | txn_bit;
               result.granted = 1'b1;
               result.status  = slt_pkg::STAT_DONE;
            end
         end
         slt_pkg::OP_LOCK_EXCL: begin
            if (excl_other) begin
               result.status = slt_pkg::STAT_CONFLICT;
            end else if (excl_mine) begin
               result.granted = 1'b1;
               result.status  = slt_pkg::STAT_DONE;
            end else if ((shared != '0) && (shared != txn_bit)) begin
               result.status = slt_pkg::STAT_CONFLICT;
            end else begin
               new_shared     = '0;
               new_excl       = txn;
               result.granted = 1'b1;
               result.status  = slt_pkg::STAT_DONE;
            end
         end
         slt_pkg::OP_REL_SHARED: begin
            if (shared_mine) begin
               new_shared     = shared & ~txn_bit;
               result.granted = 1'b1;
               result.status  = slt_pkg::STAT_DONE;
            end
         end
         slt_pkg::OP_REL_ALL: begin
            if (excl_mine || shared_mine) begin
               new_shared     = shared & ~txn_bit;
               new_excl       = excl_mine ? '0 : excl;
               result.granted = 1'b1;
               result.status  = slt_pkg::STAT_DONE;
            end
         end
         default: begin
            result.status = slt_pkg::STAT_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/shared_exclusive_lock_table.sv
`default_nettype none

// Shared/exclusive record lock table. Each request is a shared lock, an exclusive lock (which
// upgrades a sole shared holder), a shared release or a release of everything a transaction
// holds, and each gets exactly one item back with a grant flag and a status. A request from a
// valid transaction sweeps the entry memories through their single read port, one entry a
// cycle, before its result is formed; a request from transaction zero or an out-of-range
// number skips the sweep and goes straight to its result. One request is in work at a time,
// while the previous result may still wait in the output register. An entry is live exactly
// while it has an owner, so after reset the block clears the owner memory entry by entry
// and is not ready until that is done. Keys are unique among live entries, an entry with no
// owners is freed at once, and a lock on a new key when every entry is live is refused as
// table full.
module shared_exclusive_lock_table #(
   parameter int TABLE_ENTRIES = 64,
   parameter int TRANSACTIONS  = 16,
   parameter int KEY_BITS      = 48
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire slt_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output slt_pkg::rsp_item_type      rsp_item
);

   localparam int EW = $clog2(TABLE_ENTRIES);
   localparam int OW = slt_pkg::TXN_W + TRANSACTIONS;
   localparam logic [EW-1:0] LastIdx = EW'(TABLE_ENTRIES - 1);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_COMMIT = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   slt_pkg::req_item_type       req_ff, req_in;
   logic [EW-1:0]               rd_idx_ff, rd_idx_in;
   logic                        proc_ff, proc_in;
   logic [EW-1:0]               proc_idx_ff, proc_idx_in;
   logic                        found_ff, found_in;
   logic [EW-1:0]               found_idx_ff, found_idx_in;
   logic [slt_pkg::TXN_W-1:0]   found_excl_ff, found_excl_in;
   logic [TRANSACTIONS-1:0]     found_shared_ff, found_shared_in;
   logic                        free_ff, free_in;
   logic [EW-1:0]               free_idx_ff, free_idx_in;
   logic                        any_ff, any_in;
   slt_pkg::rsp_item_type       res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   slt_pkg::rsp_item_type       rsp_item_ff, rsp_item_in;

   logic [63:0]                 key_ext;
   logic [KEY_BITS-1:0]         req_key;
   logic [TRANSACTIONS-1:0]     txn_bit;
   logic                        is_lock;
   logic                        bad_txn;
   logic [KEY_BITS-1:0]         key_rd;
   logic [OW-1:0]               owner_rd;
   logic [slt_pkg::TXN_W-1:0]   rd_excl;
   logic [TRANSACTIONS-1:0]     rd_shared;
   logic                        rd_live;
   logic [slt_pkg::TXN_W-1:0]   unit_excl;
   logic [TRANSACTIONS-1:0]     unit_shared;
   slt_pkg::owner_result_type   unit_res;
   logic [slt_pkg::TXN_W-1:0]   unit_new_excl;
   logic [TRANSACTIONS-1:0]     unit_new_shared;
   logic                        key_wr_en;
   logic                        owner_wr_en;
   logic [EW-1:0]               owner_wr_addr;
   logic [OW-1:0]               owner_wr_data;
   logic [EW-1:0]               commit_idx;
   logic                        load_rsp;

   assign key_ext = 64'(req_ff.lock_key);
   assign req_key = key_ext[KEY_BITS-1:0];
   assign txn_bit = TRANSACTIONS'(1) << req_ff.transaction;
   assign is_lock = (req_ff.operation == slt_pkg::OP_LOCK_SHARED)
                 || (req_ff.operation == slt_pkg::OP_LOCK_EXCL);
   assign bad_txn = (req_item.transaction == '0)
                 || (32'(req_item.transaction) >= TRANSACTIONS);
   assign rd_excl   = owner_rd[OW-1 -: slt_pkg::TXN_W];
   assign rd_shared = owner_rd[TRANSACTIONS-1:0];
   assign rd_live   = (rd_excl != '0) || (rd_shared != '0);
   assign commit_idx = found_ff ? found_idx_ff : free_idx_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign unit_excl   = (state_ff == ST_COMMIT) ? found_excl_ff : rd_excl;
   assign unit_shared = (state_ff == ST_COMMIT) ? found_shared_ff : rd_shared;

   slt_owner_unit #(
      .TRANSACTIONS(TRANSACTIONS)
   ) u_owner (
      .operation (req_ff.operation),
      .txn       (req_ff.transaction),
      .txn_bit   (txn_bit),
      .excl      (unit_excl),
      .shared    (unit_shared),
      .result    (unit_res),
      .new_excl  (unit_new_excl),
      .new_shared(unit_new_shared)
   );

   slt_ram #(
      .WIDTH(KEY_BITS),
      .DEPTH(TABLE_ENTRIES)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (key_wr_en),
      .wr_addr(free_idx_ff),
      .wr_data(req_key),
      .rd_addr(rd_idx_ff),
      .rd_data(key_rd)
   );

   slt_ram #(
      .WIDTH(OW),
      .DEPTH(TABLE_ENTRIES)
   ) u_owner_ram (
      .clock  (clock),
      .wr_en  (owner_wr_en),
      .wr_addr(owner_wr_addr),
      .wr_data(owner_wr_data),
      .rd_addr(rd_idx_ff),
      .rd_data(owner_rd)
   );

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      rd_idx_in       = rd_idx_ff;
      proc_in         = 1'b0;
      proc_idx_in     = proc_idx_ff;
      found_in        = found_ff;
      found_idx_in    = found_idx_ff;
      found_excl_in   = found_excl_ff;
      found_shared_in = found_shared_ff;
      free_in         = free_ff;
      free_idx_in     = free_idx_ff;
      any_in          = any_ff;
      res_in          = res_ff;
      key_wr_en       = 1'b0;
      owner_wr_en     = 1'b0;
      owner_wr_addr   = proc_idx_ff;
      owner_wr_data   = {unit_new_excl, unit_new_shared};
      load_rsp        = 1'b0;

      // Each entry read in the sweep is examined in the cycle after its read.
      if (proc_ff) begin
         if (req_ff.operation == slt_pkg::OP_REL_ALL) begin
            if (unit_res.granted) begin
               owner_wr_en = 1'b1;
               any_in      = 1'b1;
            end
         end else begin
            if (rd_live && (key_rd == req_key) && !found_ff) begin
               found_in        = 1'b1;
               found_idx_in    = proc_idx_ff;
               found_excl_in   = rd_excl;
               found_shared_in = rd_shared;
            end
            if (!rd_live && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = proc_idx_ff;
            end
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            owner_wr_en   = 1'b1;
            owner_wr_addr = rd_idx_ff;
            owner_wr_data = '0;
            if (rd_idx_ff == LastIdx) begin
               state_in = ST_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff + EW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in          = req_item;
               rd_idx_in       = '0;
               found_in        = 1'b0;
               found_excl_in   = '0;
               found_shared_in = '0;
               free_in         = 1'b0;
               any_in          = 1'b0;
               if (bad_txn) begin
                  res_in.granted = 1'b0;
                  res_in.status  = ((req_item.operation == slt_pkg::OP_LOCK_SHARED)
                                 || (req_item.operation == slt_pkg::OP_LOCK_EXCL))
                                 ? slt_pkg::STAT_CONFLICT : slt_pkg::STAT_NONE;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            proc_in     = 1'b1;
            proc_idx_in = rd_idx_ff;
            if (rd_idx_ff == LastIdx) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + EW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            owner_wr_addr = commit_idx;
            if (req_ff.operation == slt_pkg::OP_REL_ALL) begin
               res_in.granted = any_ff;
               res_in.status  = any_ff ? slt_pkg::STAT_DONE : slt_pkg::STAT_NONE;
            end else if (is_lock && !found_ff && !free_ff) begin
               res_in.granted = 1'b0;
               res_in.status  = slt_pkg::STAT_FULL;
            end else begin
               res_in.granted = unit_res.granted;
               res_in.status  = unit_res.status;
               if (unit_res.granted) begin
                  owner_wr_en = 1'b1;
                  if (is_lock && !found_ff) begin
                     key_wr_en = 1'b1;
                  end
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_item_in = load_rsp ? res_ff : rsp_item_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rd_idx_ff    <= '0;
         proc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         proc_ff      <= proc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      proc_idx_ff     <= proc_idx_in;
      found_ff        <= found_in;
      found_idx_ff    <= found_idx_in;
      found_excl_ff   <= found_excl_in;
      found_shared_ff <= found_shared_in;
      free_ff         <= free_in;
      free_idx_ff     <= free_idx_in;
      any_ff          <= any_in;
      res_ff          <= res_in;
      rsp_item_ff     <= rsp_item_in;
   end

endmodule

`default_nettype wire
